// ===== rtl/spc_pkg.sv =====
// Shared types and constants of the string pool compactor.
// Holds the item structs, action and result codes and pool geometry.
// No dependencies.
`timescale 1ns / 1ps

package spc_pkg;

  localparam int unsigned POOL_BYTES = 4096;
  localparam int unsigned AW         = 12;  // pool byte address
  localparam int unsigned LW         = 13;  // lengths and sizes, up to POOL_BYTES

  localparam logic [2:0] A_CLEAR   = 3'd0;
  localparam logic [2:0] A_ALLOC   = 3'd1;
  localparam logic [2:0] A_WRITE   = 3'd2;
  localparam logic [2:0] A_READ    = 3'd3;
  localparam logic [2:0] A_ADD_REF = 3'd4;
  localparam logic [2:0] A_COMPACT = 3'd5;

  localparam logic [2:0] K_ACK     = 3'd0;
  localparam logic [2:0] K_ALLOC   = 3'd1;
  localparam logic [2:0] K_READ    = 3'd2;
  localparam logic [2:0] K_REF     = 3'd3;
  localparam logic [2:0] K_RELOC   = 3'd4;
  localparam logic [2:0] K_DONE    = 3'd5;

  // Word index of the pool_size register on the configuration port.
  localparam logic CFG_IDX_POOL_SIZE = 1'b0;

  typedef struct packed {
    logic [2:0]  action;
    logic [12:0] length;
    logic [11:0] offset;
    logic [7:0]  data_byte;
    logic [15:0] ref_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        ok;
    logic [11:0] result_offset;
    logic [7:0]  read_byte;
    logic [15:0] tag_out;
    logic [12:0] freed_bytes;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [11:0] off;
    logic [12:0] len;
  } live_ent_t;

endpackage

// ===== rtl/spc_cfg.sv =====
// Configuration register block of the string pool compactor.
// Holds pool_size behind an APB-style port and derives the usable size.
// Depends on spc_pkg.
`timescale 1ns / 1ps

module spc_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [12:0] size_o
);

  logic [12:0] pool_size_q, pool_size_d;
  logic        sel_pool;

  assign pready   = 1'b1;
  assign sel_pool = (paddr[2] == spc_pkg::CFG_IDX_POOL_SIZE);

  always_comb begin
    pool_size_d = pool_size_q;
    if (psel && penable && pwrite && sel_pool) begin
      pool_size_d = pwdata[12:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= 13'(spc_pkg::POOL_BYTES);
    end else begin
      pool_size_q <= pool_size_d;
    end
  end

  assign prdata = sel_pool ? {19'd0, pool_size_q} : 32'd0;

  // The register may be set above the physical pool; the usable size is capped.
  assign size_o = (pool_size_q > 13'(spc_pkg::POOL_BYTES)) ? 13'(spc_pkg::POOL_BYTES)
                                                           : pool_size_q;

endmodule

// ===== rtl/string_pool_compactor_top.sv =====
// String pool compactor: simple actions take one item per cycle unless a compaction or an
// output stall holds the input; each result passes the payload and then the output register.
// A compaction holds the input until its done result is loaded, copying one byte at a time
// through the pool and scratch memories (snapshot pass, then copy-back).
// Reset clears the used count, live count and sequencer and sets pool_size to POOL_BYTES; pool, scratch and
// the live table hold no defined contents until written, and no clearing pass is run.
`timescale 1ns / 1ps

module string_pool_compactor_top #(
  parameter int unsigned MAX_REFS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spc_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned IW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int unsigned CW = $clog2(MAX_REFS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DRAIN = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SCHK  = 4'd3;
  localparam logic [3:0] S_SCOPY = 4'd4;
  localparam logic [3:0] S_CRD   = 4'd5;
  localparam logic [3:0] S_CEMIT = 4'd6;
  localparam logic [3:0] S_CCOPY = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [12:0] size;

  spc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size_o  (size)
  );

  // Memories.
  logic [7:0]          pool_mem [spc_pkg::POOL_BYTES];
  logic [7:0]          scr_mem  [spc_pkg::POOL_BYTES];
  spc_pkg::live_ent_t  tbl_mem  [MAX_REFS];

  logic                pool_we, pool_re, scr_we, scr_re, tbl_we, tbl_re;
  logic [11:0]         pool_wa, pool_ra, scr_ra;
  logic [7:0]          pool_wd;
  logic [7:0]          pool_rd_q, scr_rd_q;
  spc_pkg::live_ent_t  tbl_rd_q, tbl_wd;

  // Control state.
  logic [12:0]         used_q, used_d;
  logic [CW-1:0]       live_cnt_q, live_cnt_d;
  logic [3:0]          seq_q, seq_d;
  logic [CW-1:0]       n_q, n_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [12:0]         prev_used_q, prev_used_d;
  logic [12:0]         ti_q, ti_d;
  logic [12:0]         cnt_q, cnt_d;
  logic [11:0]         src_q, src_d, dst_q, dst_d;
  logic [MAX_REFS-1:0] fits_q, fits_d;
  logic                cp_we_q, cp_we_d, cp_to_pool_q, cp_to_pool_d;
  logic [11:0]         cp_wa_q, cp_wa_d;

  logic                p_valid_q, out_valid_q;
  spc_pkg::out_item_t  p_item_q, out_item_q, acc_item, seq_item, fwd_item;
  logic                p_adv, p_free, acc, acc_pload, seq_pload;

  logic                busy;
  logic [13:0]         alloc_end, ref_end, chk_end, chk_src_end;
  logic                in_rng, ref_ok, last_ref, chk_fits;

  assign busy   = (seq_q != S_IDLE);
  assign p_adv  = !out_valid_q || !out_stall_i;
  assign p_free = !p_valid_q || p_adv;

  assign in_stall_o = busy || !p_free;
  assign acc        = in_valid_i && !in_stall_o;

  assign alloc_end = {1'b0, used_q} + {1'b0, in_item_i.length};
  assign ref_end   = 14'(in_item_i.offset) + {1'b0, in_item_i.length};
  assign in_rng    = ({1'b0, in_item_i.offset} < size);
  assign ref_ok    = (live_cnt_q < CW'(MAX_REFS)) && (in_item_i.length != 13'd0) &&
                     (ref_end <= {1'b0, size});

  assign chk_end     = {1'b0, ti_q} + {1'b0, tbl_rd_q.len};
  assign chk_src_end = 14'(tbl_rd_q.off) + {1'b0, tbl_rd_q.len};
  assign chk_fits    = (chk_end <= {1'b0, size}) &&
                       (chk_src_end <= 14'(spc_pkg::POOL_BYTES));
  assign last_ref    = ((CW'(idx_q) + CW'(1)) == n_q);

  // Accept side: simple actions finish here, compaction hands over to the sequencer.
  always_comb begin
    acc_item   = '0;
    acc_item.last = 1'b1;
    acc_pload  = 1'b0;
    tbl_we     = 1'b0;
    tbl_wd     = '{tag: in_item_i.ref_tag, off: in_item_i.offset, len: in_item_i.length};
    used_d     = used_q;
    live_cnt_d = live_cnt_q;
    if (acc) begin
      unique case (in_item_i.action)
        spc_pkg::A_CLEAR: begin
          acc_pload   = 1'b1;
          acc_item.ok = 1'b1;
          used_d      = '0;
          live_cnt_d  = '0;
        end
        spc_pkg::A_ALLOC: begin
          acc_pload     = 1'b1;
          acc_item.kind = spc_pkg::K_ALLOC;
          if (alloc_end <= {1'b0, size}) begin
            acc_item.ok            = 1'b1;
            acc_item.result_offset = used_q[11:0];
            used_d                 = alloc_end[12:0];
          end
        end
        spc_pkg::A_WRITE: begin
          acc_pload   = 1'b1;
          acc_item.ok = in_rng;
        end
        spc_pkg::A_READ: begin
          acc_pload     = 1'b1;
          acc_item.kind = spc_pkg::K_READ;
          acc_item.ok   = in_rng;
        end
        spc_pkg::A_ADD_REF: begin
          acc_pload        = 1'b1;
          acc_item.kind    = spc_pkg::K_REF;
          acc_item.ok      = ref_ok;
          acc_item.tag_out = in_item_i.ref_tag;
          if (ref_ok) begin
            tbl_we     = 1'b1;
            live_cnt_d = live_cnt_q + CW'(1);
          end
        end
        spc_pkg::A_COMPACT: begin
          live_cnt_d    = '0;
          acc_item.kind = spc_pkg::K_DONE;
          acc_item.ok   = 1'b1;
          if (used_q == 13'd0) begin
            acc_pload = 1'b1;
          end else if (live_cnt_q == '0) begin
            acc_pload            = 1'b1;
            acc_item.freed_bytes = used_q;
            used_d               = '0;
          end
        end
        default: begin
          acc_pload = 1'b1;
        end
      endcase
    end
    if (seq_q == S_DONE && p_free) begin
      used_d = ti_q;
    end
  end

  // Compaction sequencer: snapshot each fitting ref into scratch, then copy back.
  always_comb begin
    seq_d        = seq_q;
    n_d          = n_q;
    idx_d        = idx_q;
    prev_used_d  = prev_used_q;
    ti_d         = ti_q;
    cnt_d        = cnt_q;
    src_d        = src_q;
    dst_d        = dst_q;
    fits_d       = fits_q;
    cp_we_d      = 1'b0;
    cp_to_pool_d = cp_to_pool_q;
    cp_wa_d      = cp_wa_q;
    seq_pload    = 1'b0;
    seq_item     = '0;
    tbl_re       = 1'b0;
    scr_re       = 1'b0;
    unique case (seq_q)
      S_IDLE: begin
        if (acc && in_item_i.action == spc_pkg::A_COMPACT && used_q != 13'd0 &&
            live_cnt_q != '0) begin
          seq_d       = S_DRAIN;
          n_d         = live_cnt_q;
          prev_used_d = used_q;
          idx_d       = '0;
          ti_d        = '0;
        end
      end
      S_DRAIN: begin
        // The pool read register still serves a pending read item until it moves on.
        if (!p_valid_q) begin
          seq_d = S_SRD;
        end
      end
      S_SRD: begin
        tbl_re = 1'b1;
        seq_d  = S_SCHK;
      end
      S_SCHK: begin
        fits_d[idx_q] = chk_fits;
        if (chk_fits) begin
          src_d = tbl_rd_q.off;
          dst_d = ti_q[11:0];
          cnt_d = tbl_rd_q.len;
          ti_d  = chk_end[12:0];
          seq_d = S_SCOPY;
        end else if (last_ref) begin
          idx_d = '0;
          dst_d = '0;
          seq_d = S_CRD;
        end else begin
          idx_d = idx_q + IW'(1);
          seq_d = S_SRD;
        end
      end
      S_SCOPY: begin
        cp_we_d      = 1'b1;
        cp_to_pool_d = 1'b0;
        cp_wa_d      = dst_q;
        src_d        = src_q + 12'd1;
        dst_d        = dst_q + 12'd1;
        cnt_d        = cnt_q - 13'd1;
        if (cnt_q == 13'd1) begin
          if (last_ref) begin
            idx_d = '0;
            dst_d = '0;
            seq_d = S_CRD;
          end else begin
            idx_d = idx_q + IW'(1);
            seq_d = S_SRD;
          end
        end
      end
      S_CRD: begin
        tbl_re = 1'b1;
        seq_d  = S_CEMIT;
      end
      S_CEMIT: begin
        // dst_q carries the packed offset of the next fitting ref through this pass.
        if (p_free) begin
          seq_pload        = 1'b1;
          seq_item.kind    = spc_pkg::K_RELOC;
          seq_item.tag_out = tbl_rd_q.tag;
          seq_item.ok      = fits_q[idx_q];
          if (fits_q[idx_q]) begin
            seq_item.result_offset = dst_q;
            cnt_d = tbl_rd_q.len;
            seq_d = S_CCOPY;
          end else if (last_ref) begin
            seq_d = S_DONE;
          end else begin
            idx_d = idx_q + IW'(1);
            seq_d = S_CRD;
          end
        end
      end
      S_CCOPY: begin
        scr_re       = 1'b1;
        cp_we_d      = 1'b1;
        cp_to_pool_d = 1'b1;
        cp_wa_d      = dst_q;
        dst_d        = dst_q + 12'd1;
        cnt_d        = cnt_q - 13'd1;
        if (cnt_q == 13'd1) begin
          if (last_ref) begin
            seq_d = S_DONE;
          end else begin
            idx_d = idx_q + IW'(1);
            seq_d = S_CRD;
          end
        end
      end
      S_DONE: begin
        if (p_free) begin
          seq_pload            = 1'b1;
          seq_item.kind        = spc_pkg::K_DONE;
          seq_item.ok          = 1'b1;
          seq_item.last        = 1'b1;
          seq_item.freed_bytes = (prev_used_q > ti_q) ? (prev_used_q - ti_q) : 13'd0;
          seq_d                = S_IDLE;
        end
      end
      default: begin
        seq_d = S_IDLE;
      end
    endcase
  end

  // Memory port selection.
  assign pool_we = (cp_we_q && cp_to_pool_q) ||
                   (acc && in_item_i.action == spc_pkg::A_WRITE && in_rng);
  assign pool_wa = cp_we_q ? cp_wa_q : in_item_i.offset;
  assign pool_wd = cp_we_q ? scr_rd_q : in_item_i.data_byte;
  assign pool_re = (seq_q == S_SCOPY) || (acc && in_item_i.action == spc_pkg::A_READ);
  assign pool_ra = (seq_q == S_SCOPY) ? src_q : in_item_i.offset;
  assign scr_we  = cp_we_q && !cp_to_pool_q;
  assign scr_ra  = dst_q;

  always_ff @(posedge clk_i) begin
    if (pool_we) begin
      pool_mem[pool_wa] <= pool_wd;
    end
    if (pool_re) begin
      pool_rd_q <= pool_mem[pool_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (scr_we) begin
      scr_mem[cp_wa_q] <= pool_rd_q;
    end
    if (scr_re) begin
      scr_rd_q <= scr_mem[scr_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[live_cnt_q[IW-1:0]] <= tbl_wd;
    end
    if (tbl_re) begin
      tbl_rd_q <= tbl_mem[idx_q];
    end
  end

  // A read item picks up its byte from the pool read register as it moves out.
  always_comb begin
    fwd_item = p_item_q;
    if (p_item_q.kind == spc_pkg::K_READ && p_item_q.ok) begin
      fwd_item.read_byte = pool_rd_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (acc_pload) begin
      p_item_q <= acc_item;
    end else if (seq_pload) begin
      p_item_q <= seq_item;
    end
    if (p_valid_q && p_adv) begin
      out_item_q <= fwd_item;
    end
    idx_q       <= idx_d;
    prev_used_q <= prev_used_d;
    cnt_q       <= cnt_d;
    src_q       <= src_d;
    dst_q       <= dst_d;
    fits_q      <= fits_d;
    cp_wa_q     <= cp_wa_d;
    cp_to_pool_q <= cp_to_pool_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      live_cnt_q  <= '0;
      seq_q       <= S_IDLE;
      n_q         <= '0;
      ti_q        <= '0;
      cp_we_q     <= 1'b0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      used_q     <= used_d;
      live_cnt_q <= live_cnt_d;
      seq_q      <= seq_d;
      n_q        <= n_d;
      ti_q       <= ti_d;
      cp_we_q    <= cp_we_d;
      if (acc_pload || seq_pload) begin
        p_valid_q <= 1'b1;
      end else if (p_adv) begin
        p_valid_q <= 1'b0;
      end
      if (p_valid_q && p_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A pending copy write always belongs to a running compaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cp_we_q |-> busy)
    else $error("copy write outside compaction");

  // The snapshot pass must not disturb read data owed to a queued item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == S_SCOPY) |-> !p_valid_q)
    else $error("snapshot read while a result waits for pool data");

  assert property (@(posedge clk_i) disable iff (!rst_ni) live_cnt_q <= CW'(MAX_REFS))
    else $error("live count beyond table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= 13'(spc_pkg::POOL_BYTES))
    else $error("used bytes beyond pool");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the string pool compactor (string_pool_compactor_top).
// Keeps its own model of the pool, drives actions through a queue-fed driver and
// checks every result item in a clocked monitor. Depends on spc_pkg.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned CHK = 0;  // model instance behind the checker
  localparam int unsigned GEN = 1;  // model instance the stimulus is planned with
  localparam int unsigned REFS = 32;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  spc_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  spc_pkg::out_item_t out_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  string_pool_compactor_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Pool state, kept twice: once for checking, once for planning stimulus.
  logic [7:0] pool_bytes [2][spc_pkg::POOL_BYTES];
  bit byte_known [2][spc_pkg::POOL_BYTES];
  logic [7:0] snap_bytes [spc_pkg::POOL_BYTES];
  bit snap_known [spc_pkg::POOL_BYTES];
  int unsigned used_cnt [2];
  int unsigned live_cnt [2];
  int unsigned live_tag [2][REFS];
  int unsigned live_off [2][REFS];
  int unsigned live_len [2][REFS];
  int unsigned pool_limit [2];

  spc_pkg::in_item_t pending_actions [$];
  spc_pkg::out_item_t expected_results [$];
  int unsigned n_errors = 0;
  int unsigned n_planned = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;

  function automatic int unsigned eff_size(int unsigned m);
    return (pool_limit[m] < spc_pkg::POOL_BYTES) ? pool_limit[m] : spc_pkg::POOL_BYTES;
  endfunction

  function automatic spc_pkg::out_item_t result_of(logic [2:0] kind, bit ok,
                                                   int unsigned roff, logic [7:0] rbyte,
                                                   int unsigned tag, int unsigned freed,
                                                   bit last);
    spc_pkg::out_item_t r;
    r.kind = kind;
    r.ok = ok;
    r.result_offset = roff[11:0];
    r.read_byte = rbyte;
    r.tag_out = tag[15:0];
    r.freed_bytes = freed[12:0];
    r.last = last;
    return r;
  endfunction

  // Applies one action to model instance m; only the checking instance records results.
  function automatic void pool_apply(int unsigned m, spc_pkg::in_item_t it);
    int unsigned size, prev_used, n, ti, nu;
    bit fits [REFS];
    spc_pkg::out_item_t res [$];
    size = eff_size(m);
    case (it.action)
      spc_pkg::A_CLEAR: begin
        used_cnt[m] = 0;
        live_cnt[m] = 0;
        res.push_back(result_of(spc_pkg::K_ACK, 1, 0, 0, 0, 0, 1));
      end
      spc_pkg::A_ALLOC: begin
        if (used_cnt[m] + it.length > size) begin
          res.push_back(result_of(spc_pkg::K_ALLOC, 0, 0, 0, 0, 0, 1));
        end else begin
          res.push_back(result_of(spc_pkg::K_ALLOC, 1, used_cnt[m], 0, 0, 0, 1));
          used_cnt[m] += it.length;
        end
      end
      spc_pkg::A_WRITE: begin
        if (it.offset < size) begin
          pool_bytes[m][it.offset] = it.data_byte;
          byte_known[m][it.offset] = 1'b1;
        end
        res.push_back(result_of(spc_pkg::K_ACK, it.offset < size, 0, 0, 0, 0, 1));
      end
      spc_pkg::A_READ: begin
        if (it.offset < size)
          res.push_back(result_of(spc_pkg::K_READ, 1, 0, pool_bytes[m][it.offset],
                                  0, 0, 1));
        else
          res.push_back(result_of(spc_pkg::K_READ, 0, 0, 0, 0, 0, 1));
      end
      spc_pkg::A_ADD_REF: begin
        if (live_cnt[m] >= REFS || it.length == 0 || it.offset + it.length > size) begin
          res.push_back(result_of(spc_pkg::K_REF, 0, 0, 0, it.ref_tag, 0, 1));
        end else begin
          live_tag[m][live_cnt[m]] = it.ref_tag;
          live_off[m][live_cnt[m]] = it.offset;
          live_len[m][live_cnt[m]] = it.length;
          live_cnt[m]++;
          res.push_back(result_of(spc_pkg::K_REF, 1, 0, 0, it.ref_tag, 0, 1));
        end
      end
      spc_pkg::A_COMPACT: begin
        prev_used = used_cnt[m];
        n = live_cnt[m];
        live_cnt[m] = 0;
        if (prev_used == 0) begin
          res.push_back(result_of(spc_pkg::K_DONE, 1, 0, 0, 0, 0, 1));
        end else if (n == 0) begin
          used_cnt[m] = 0;
          res.push_back(result_of(spc_pkg::K_DONE, 1, 0, 0, 0, prev_used, 1));
        end else begin
          ti = 0;
          for (int i = 0; i < n; i++) begin
            fits[i] = (ti + live_len[m][i] <= size) &&
                      (live_off[m][i] + live_len[m][i] <= spc_pkg::POOL_BYTES);
            if (fits[i]) begin
              for (int b = 0; b < live_len[m][i]; b++) begin
                snap_bytes[ti + b] = pool_bytes[m][live_off[m][i] + b];
                snap_known[ti + b] = byte_known[m][live_off[m][i] + b];
              end
              ti += live_len[m][i];
            end
          end
          nu = 0;
          for (int i = 0; i < n; i++) begin
            if (fits[i]) begin
              for (int b = 0; b < live_len[m][i]; b++) begin
                pool_bytes[m][nu + b] = snap_bytes[nu + b];
                byte_known[m][nu + b] = snap_known[nu + b];
              end
              res.push_back(result_of(spc_pkg::K_RELOC, 1, nu, 0, live_tag[m][i], 0, 0));
              nu += live_len[m][i];
            end else begin
              res.push_back(result_of(spc_pkg::K_RELOC, 0, 0, 0, live_tag[m][i], 0, 0));
            end
          end
          used_cnt[m] = nu;
          res.push_back(result_of(spc_pkg::K_DONE, 1, 0, 0, 0,
                                  (prev_used > nu) ? prev_used - nu : 0, 1));
        end
      end
      default: res.push_back(result_of(spc_pkg::K_ACK, 0, 0, 0, 0, 0, 1));
    endcase
    if (m == CHK)
      foreach (res[i]) expected_results.push_back(res[i]);
  endfunction

  function automatic spc_pkg::in_item_t action_item(logic [2:0] action, int unsigned len,
                                                    int unsigned off, int unsigned data,
                                                    int unsigned tag);
    spc_pkg::in_item_t it;
    it.action = action;
    it.length = len[12:0];
    it.offset = off[11:0];
    it.data_byte = data[7:0];
    it.ref_tag = tag[15:0];
    return it;
  endfunction

  function automatic void plan(spc_pkg::in_item_t it);
    pool_apply(GEN, it);
    pending_actions.push_back(it);
    n_planned++;
  endfunction

  // A read must never land on a byte that was never written inside the pool.
  function automatic void plan_read(int unsigned hint);
    int unsigned size, off;
    bit found;
    size = eff_size(GEN);
    off = hint % spc_pkg::POOL_BYTES;
    found = (off >= size) || byte_known[GEN][off];
    for (int k = 0; k < 64 && !found; k++) begin
      off = $urandom_range(spc_pkg::POOL_BYTES - 1);
      found = (off >= size) || byte_known[GEN][off];
    end
    if (found)
      plan(action_item(spc_pkg::A_READ, $urandom, off, $urandom, $urandom));
    else
      plan(action_item(spc_pkg::A_WRITE, $urandom, off, $urandom, $urandom));
  endfunction

  // Driver: a predicted action enters the checking model as it is accepted.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        pool_apply(CHK, in_item);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_actions.size() > 0 &&
            ((n_accepted >= 50 && n_accepted < 85) || $urandom_range(99) >= 27)) begin
          in_item <= pending_actions.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results and drives the output stall, with one long hold-off.
  always @(posedge clk or negedge rst_n) begin
    spc_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_results.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
        end else begin
          want = expected_results.pop_front();
          if (out_item !== want) begin
            n_errors++;
            $display("%0t: result mismatch, expected %h, actual %h", $time, want, out_item);
            $display("  kind %0d/%0d ok %0d/%0d off %0d/%0d byte %0d/%0d tag %0d/%0d",
                     want.kind, out_item.kind, want.ok, out_item.ok, want.result_offset,
                     out_item.result_offset, want.read_byte, out_item.read_byte,
                     want.tag_out, out_item.tag_out);
            $display("  freed %0d/%0d last %0d/%0d", want.freed_bytes,
                     out_item.freed_bytes, want.last, out_item.last);
          end
        end
      end
      if (!hold_done && n_results >= 40) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= (hold_left > 1);
      end else if (n_results >= 90 && n_results < 140) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 27);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_actions.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pool_size(int unsigned value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {spc_pkg::CFG_IDX_POOL_SIZE, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pool_limit[CHK] = value & 13'h1fff;
    pool_limit[GEN] = value & 13'h1fff;
    @(negedge clk);
  endtask

  // Allocates a few strings, fills them, records refs over them, compacts, reads back.
  task automatic plan_lifecycle();
    int unsigned n, len, base, span, start;
    if ($urandom_range(2) == 0) plan(action_item(spc_pkg::A_CLEAR, 0, 0, 0, 0));
    n = $urandom_range(1, 6);
    for (int s = 0; s < n; s++) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(100, 600) : $urandom_range(1, 24);
      base = used_cnt[GEN];
      plan(action_item(spc_pkg::A_ALLOC, len, 0, 0, $urandom));
      if (used_cnt[GEN] == base) continue;
      for (int w = $urandom_range(0, (len < 6) ? len : 6); w > 0; w--)
        plan(action_item(spc_pkg::A_WRITE, $urandom, base + $urandom_range(len - 1),
                         $urandom, $urandom));
      if ($urandom_range(3) != 0) begin
        start = $urandom_range(len - 1);
        span = $urandom_range(1, len - start);
        plan(action_item(spc_pkg::A_ADD_REF, span, base + start, 0, $urandom));
      end
    end
    if ($urandom_range(4) == 0)
      plan(action_item(spc_pkg::A_ADD_REF, $urandom_range(1, 8),
                       $urandom_range(used_cnt[GEN]), 0, $urandom));
    if ($urandom_range(1) == 0) plan_read($urandom);
    plan(action_item(spc_pkg::A_COMPACT, $urandom, $urandom, $urandom, $urandom));
    for (int r = $urandom_range(1, 4); r > 0; r--)
      plan_read((used_cnt[GEN] > 0) ? $urandom_range(used_cnt[GEN] - 1) : $urandom);
  endtask

  task automatic plan_noise();
    logic [2:0] action;
    int unsigned len;
    action = $urandom_range(7);
    len = ($urandom_range(7) == 0) ? $urandom_range(4096) : $urandom_range(64);
    if (action == spc_pkg::A_READ)
      plan_read($urandom);
    else
      plan(action_item(action, len, $urandom, $urandom, $urandom));
  endtask

  initial begin
    foreach (byte_known[m, i]) byte_known[m][i] = 1'b0;
    for (int m = 0; m < 2; m++) begin
      used_cnt[m] = 0;
      live_cnt[m] = 0;
      pool_limit[m] = 4096;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    set_pool_size(4096);

    // Directed: empty compact, full pool, boundaries, unknown actions, ref rejects.
    plan(action_item(spc_pkg::A_COMPACT, 0, 0, 0, 0));
    plan(action_item(spc_pkg::A_ALLOC, 4096, 0, 0, 0));
    plan(action_item(spc_pkg::A_ALLOC, 0, 0, 0, 0));
    plan(action_item(spc_pkg::A_ALLOC, 1, 0, 0, 0));
    plan(action_item(spc_pkg::A_WRITE, 0, 4095, 255, 0));
    plan(action_item(spc_pkg::A_WRITE, 0, 0, 8'h5a, 0));
    plan(action_item(spc_pkg::A_READ, 0, 4095, 0, 0));
    plan(action_item(spc_pkg::A_READ, 0, 0, 0, 0));
    plan(action_item(3'd6, 8191, 4095, 255, 65535));
    plan(action_item(3'd7, 0, 0, 0, 0));
    plan(action_item(spc_pkg::A_ADD_REF, 0, 0, 0, 65535));
    plan(action_item(spc_pkg::A_ADD_REF, 2, 4095, 0, 1));
    plan(action_item(spc_pkg::A_ADD_REF, 8, 0, 0, 65535));
    plan(action_item(spc_pkg::A_ADD_REF, 8, 2, 0, 0));
    plan(action_item(spc_pkg::A_COMPACT, 0, 0, 0, 0));
    plan(action_item(spc_pkg::A_READ, 0, 0, 0, 0));
    // Packed total larger than the used count, then a compact with no refs.
    plan(action_item(spc_pkg::A_CLEAR, 0, 0, 0, 0));
    plan(action_item(spc_pkg::A_ALLOC, 10, 0, 0, 0));
    plan(action_item(spc_pkg::A_ADD_REF, 8, 0, 0, 16'h1234));
    plan(action_item(spc_pkg::A_ADD_REF, 8, 2, 0, 16'hedcb));
    plan(action_item(spc_pkg::A_COMPACT, 0, 0, 0, 0));
    plan(action_item(spc_pkg::A_COMPACT, 0, 0, 0, 0));
    wait_idle();

    // A small pool: out-of-range accesses, then refs that no longer fit.
    set_pool_size(16);
    plan(action_item(spc_pkg::A_ALLOC, 20, 0, 0, 0));
    plan(action_item(spc_pkg::A_ALLOC, 12, 0, 0, 0));
    plan(action_item(spc_pkg::A_WRITE, 0, 16, 8'h33, 0));
    plan(action_item(spc_pkg::A_READ, 0, 20, 0, 0));
    plan(action_item(spc_pkg::A_ADD_REF, 8, 0, 0, 16'h00aa));
    plan(action_item(spc_pkg::A_ADD_REF, 8, 4, 0, 16'h00bb));
    wait_idle();
    set_pool_size(12);
    plan(action_item(spc_pkg::A_COMPACT, 0, 0, 0, 0));
    wait_idle();
    set_pool_size(0);
    plan(action_item(spc_pkg::A_ALLOC, 1, 0, 0, 0));
    plan(action_item(spc_pkg::A_WRITE, 0, 0, 0, 0));
    wait_idle();

    // Overflow the ref table, then compact the full table.
    set_pool_size(4096);
    plan(action_item(spc_pkg::A_CLEAR, 0, 0, 0, 0));
    plan(action_item(spc_pkg::A_ALLOC, 40, 0, 0, 0));
    for (int r = 0; r < REFS + 2; r++)
      plan(action_item(spc_pkg::A_ADD_REF, 1, r, 0, $urandom));
    plan(action_item(spc_pkg::A_COMPACT, 0, 0, 0, 0));
    wait_idle();

    // Random part, with the pool size changed between phases.
    while (n_planned < 75) begin
      case ($urandom_range(3))
        0: set_pool_size(4096);
        1: set_pool_size(8191);
        2: set_pool_size($urandom_range(1, 4096));
        default: set_pool_size($urandom_range(256, 4096));
      endcase
      for (int p = 0; p < 2; p++) begin
        if ($urandom_range(9) < 7) plan_lifecycle();
        else for (int k = 0; k < 4; k++) plan_noise();
      end
      wait_idle();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
